// ===== sv/text_terminal_screen_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text terminal screen engine
// Each expects clk and arst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_SCREEN_ENGINE_DEFINES_SVH
`define TEXT_TERMINAL_SCREEN_ENGINE_DEFINES_SVH

// same-cycle implication
`define TTSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ttse_pkg.sv =====
// ----------------------------------------------------------------------------
// ttse_pkg
// Screen geometry, character codes, controller states and the command and
// status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ttse_pkg;

	localparam int ROWS   = 25;
	localparam int COLS   = 80;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] CODE_BEL   = 8'h07;
	localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RWAIT,
		ST_SCROLL
	} state_t;

	typedef struct packed {
		logic init_step;
		logic load;
		logic exec_put;
		logic scroll_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic init_last;
		logic op_read;
		logic need_scroll;
		logic scroll_last;
	} dp_sts_t;

	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
		input logic [ROW_W-1:0] top);
		logic [ROW_W:0] s;
		s = {1'b0, row} + {1'b0, top};
		if (s >= (ROW_W+1)'(ROWS)) begin
			s = s - (ROW_W+1)'(ROWS);
		end
		return s[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
		input logic [COL_W-1:0] col);
		return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

// ===== sv/ttse_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttse_ctrl
// Sequencer: clearing sweep after reset, item execution, read wait and the
// row clear of a scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module ttse_ctrl
	import ttse_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dp_sts_t sts,
	output logic         busy,
	output dp_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.init_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.op_read) state_d = ST_RWAIT;
				else if (sts.need_scroll) state_d = ST_SCROLL;
				else state_d = ST_IDLE;
			end
			ST_RWAIT: begin
				state_d = ST_IDLE;
			end
			ST_SCROLL: begin
				if (sts.scroll_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_INIT: begin
				cmd.init_step = 1'b1;
			end
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_EXEC: begin
				cmd.exec_put = !sts.op_read;
				cmd.finish   = !sts.op_read && !sts.need_scroll;
			end
			ST_RWAIT: begin
				cmd.finish = 1'b1;
			end
			ST_SCROLL: begin
				cmd.scroll_step = 1'b1;
				cmd.finish      = sts.scroll_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/ttse_dp.sv =====
// ----------------------------------------------------------------------------
// ttse_dp
// Screen store as a ring of rows, cursor and top-row registers, sweep
// counter and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ttse_dp
	import ttse_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	input  wire logic              operation,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [ROW_W-1:0]  read_row,
	input  wire logic [COL_W-1:0]  read_col,
	input  wire logic              burst_end,
	output logic                   done,
	output logic [CHAR_W-1:0]      read_char,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_col,
	output logic                   bell,
	output logic                   scrolled,
	output logic                   cursor_move
);

	logic [CHAR_W-1:0] mem [CELLS];
	logic [CHAR_W-1:0] mem_rd_q;

	logic              op_q;
	logic [CHAR_W-1:0] code_q;
	logic [ROW_W-1:0]  rrow_q;
	logic [COL_W-1:0]  rcol_q;
	logic              bend_q;

	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  top_q;
	logic [ADDR_W-1:0] cnt_q;

	logic              done_q;
	logic [CHAR_W-1:0] read_char_q;
	logic              bell_q;
	logic              scrolled_q;
	logic              move_q;

	logic              is_bel;
	logic              is_bs;
	logic              is_eol;
	logic              is_prn;
	logic              col_last;
	logic              row_last;
	logic              newline;
	logic              rd_in_range;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] scr_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CHAR_W-1:0] mem_wdata;

	assign is_bel   = (code_q == CODE_BEL);
	assign is_bs    = (code_q == CODE_BS);
	assign is_eol   = (code_q == CODE_CR) || (code_q == CODE_LF);
	assign is_prn   = !is_bel && !is_bs && !is_eol;
	assign col_last = (cur_col_q == COL_W'(COLS-1));
	assign row_last = (cur_row_q == ROW_W'(ROWS-1));
	assign newline  = is_eol || (is_prn && col_last);

	assign rd_in_range = (rrow_q < ROW_W'(ROWS)) && (rcol_q < COL_W'(COLS));
	assign rd_addr     = rd_in_range ? cell_addr(phys_row(rrow_q, top_q), rcol_q) : '0;
	assign cur_addr    = cell_addr(phys_row(cur_row_q, top_q), cur_col_q);
	assign scr_addr    = cell_addr(top_q, cnt_q[COL_W-1:0]);

	assign mem_we    = cmd.init_step || cmd.scroll_step || (cmd.exec_put && is_prn);
	assign mem_waddr = cmd.init_step ? cnt_q : (cmd.scroll_step ? scr_addr : cur_addr);
	assign mem_wdata = (cmd.init_step || cmd.scroll_step) ? SPACE_CHAR : code_q;

	assign sts.init_last   = (cnt_q == ADDR_W'(CELLS-1));
	assign sts.scroll_last = (cnt_q == ADDR_W'(COLS-1));
	assign sts.op_read     = (op_q == OP_READ);
	assign sts.need_scroll = newline && row_last;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			code_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_col;
			bend_q <= burst_end;
		end
		if (cmd.finish) begin
			read_char_q <= (sts.op_read && rd_in_range) ? mem_rd_q : '0;
			bell_q      <= !sts.op_read && is_bel;
			scrolled_q  <= cmd.scroll_step;
			move_q      <= !sts.op_read && bend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			top_q     <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.init_step) begin
				cnt_q <= sts.init_last ? '0 : cnt_q + ADDR_W'(1);
			end else if (cmd.scroll_step) begin
				cnt_q <= sts.scroll_last ? '0 : cnt_q + ADDR_W'(1);
				if (sts.scroll_last) begin
					top_q <= (top_q == ROW_W'(ROWS-1)) ? '0 : top_q + ROW_W'(1);
				end
			end
			if (cmd.exec_put) begin
				if (is_bs) begin
					if (cur_col_q != '0) cur_col_q <= cur_col_q - COL_W'(1);
				end else if (newline) begin
					cur_col_q <= '0;
					if (!row_last) cur_row_q <= cur_row_q + ROW_W'(1);
				end else if (is_prn) begin
					cur_col_q <= cur_col_q + COL_W'(1);
				end
			end
		end
	end

	assign done        = done_q;
	assign read_char   = read_char_q;
	assign cursor_row  = cur_row_q;
	assign cursor_col  = cur_col_q;
	assign bell        = bell_q;
	assign scrolled    = scrolled_q;
	assign cursor_move = move_q;

endmodule

`default_nettype wire

// ===== sv/text_terminal_screen_engine.sv =====
// ----------------------------------------------------------------------------
// text_terminal_screen_engine
// Character screen store with cursor, driven by received terminal bytes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high, and the receiver has to take
// it then. After reset the block sweeps the 2000-cell store to spaces, one cell
// a cycle, and keeps busy high until the sweep is done. A put that does not
// scroll keeps busy high while it executes and then shows its result with
// done, so a new put is not taken before the last one has executed. A read
// passes through the execute and read-wait states, as the store read port is
// registered. A put that scrolls clears the new bottom row through the single
// store write port, one cell a cycle.
`default_nettype none

`include "text_terminal_screen_engine_defines.svh"

module text_terminal_screen_engine
	import ttse_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              operation,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [ROW_W-1:0]  read_row,
	input  wire logic [COL_W-1:0]  read_col,
	input  wire logic              burst_end,
	output logic                   done,
	output logic [CHAR_W-1:0]      read_char,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_col,
	output logic                   bell,
	output logic                   scrolled,
	output logic                   cursor_move
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	ttse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	ttse_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.char_code   (char_code),
		.read_row    (read_row),
		.read_col    (read_col),
		.burst_end   (burst_end),
		.done        (done),
		.read_char   (read_char),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col),
		.bell        (bell),
		.scrolled    (scrolled),
		.cursor_move (cursor_move)
	);

	`TTSE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`TTSE_ASSERT_NEXT(a_done_single, done, !done, "result beats back to back")
	`TTSE_ASSERT_NOW(a_cursor_range, 1'b1, (cursor_row < ROW_W'(ROWS)) && (cursor_col < COL_W'(COLS)), "cursor off screen")
	`TTSE_ASSERT_NOW(a_scroll_pos, done && scrolled, (cursor_row == ROW_W'(ROWS-1)) && (cursor_col == '0), "scroll left cursor off bottom-left")
	`TTSE_ASSERT_NOW(a_bell_excl, done && bell, !scrolled && (read_char == '0), "bell beat carries other flags")

endmodule

`default_nettype wire
